>>> rtl/wmfa_pkg.sv
// Shared types, constants and the CRC-16 byte update for the format A deframer.
package wmfa_pkg;

  localparam logic [7:0]  SYNC_FIRST       = 8'h54;
  localparam logic [7:0]  SYNC_SECOND      = 8'hCD;
  localparam logic [15:0] CRC_POLY         = 16'h3D65;
  localparam logic [7:0]  FIRST_BLOCK_REST = 8'd9;
  localparam logic [7:0]  FULL_BLOCK       = 8'd16;
  localparam logic [7:0]  MIN_LENGTH_RST   = 8'd9;
  localparam logic [7:0]  MAX_LENGTH_RST   = 8'd200;

  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_MIN_LENGTH = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH = 3'd4;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SYNC   = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_CRC_ERROR  = 3'd3,
    ST_ABORTED    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SYNC2  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_FRAME  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CF_DATA = 2'd0,
    CF_HIGH = 2'd1,
    CF_LOW  = 2'd2
  } crc_field_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic [7:0] min_length;
    logic [7:0] max_length;
  } limits_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/wmfa_cfg_regs.sv
// Configuration register file holding the accepted length limits.
module wmfa_cfg_regs import wmfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output limits_t           limits
);

  logic [7:0] min_length;
  logic [7:0] max_length;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      case (paddr)
        ADDR_MIN_LENGTH: min_length <= pwdata[7:0];
        ADDR_MAX_LENGTH: max_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_MIN_LENGTH: prdata = {24'd0, min_length};
      ADDR_MAX_LENGTH: prdata = {24'd0, max_length};
      default:         prdata = 32'd0;
    endcase
  end

  assign limits.min_length = min_length;
  assign limits.max_length = max_length;

endmodule

>>> rtl/wmfa_parser.sv
// Frame parser: sync hunt, length check, block tracking and CRC check per beat.
module wmfa_parser import wmfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       restart,
  input  limits_t    limits,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [4:0]  block_bytes_left, block_bytes_left_next;
  logic [7:0]  data_bytes_left, data_bytes_left_next;
  crc_field_t  crc_field_phase, crc_field_phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic        frame_error, frame_error_next;

  logic [15:0] crc_step;
  logic [4:0]  blk_dec;
  logic        crc_bad;
  logic [4:0]  next_size;

  assign crc_step  = crc_update(running_crc, rx_byte);
  assign blk_dec   = (block_bytes_left != 5'd0) ? block_bytes_left - 5'd1 : 5'd0;
  assign crc_bad   = {crc_high_byte, rx_byte} != ~running_crc;
  assign next_size = (data_bytes_left > FULL_BLOCK) ? FULL_BLOCK[4:0] : data_bytes_left[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      block_bytes_left <= 5'd0;
      data_bytes_left  <= 8'd0;
      crc_field_phase  <= CF_DATA;
      running_crc      <= 16'd0;
      crc_high_byte    <= 8'd0;
      frame_error      <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      block_bytes_left <= block_bytes_left_next;
      data_bytes_left  <= data_bytes_left_next;
      crc_field_phase  <= crc_field_phase_next;
      running_crc      <= running_crc_next;
      crc_high_byte    <= crc_high_byte_next;
      frame_error      <= frame_error_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    block_bytes_left_next = block_bytes_left;
    data_bytes_left_next  = data_bytes_left;
    crc_field_phase_next  = crc_field_phase;
    running_crc_next      = running_crc;
    crc_high_byte_next    = crc_high_byte;
    frame_error_next      = frame_error;
    result.valid          = 1'b0;
    result.data           = 8'd0;
    result.last           = 1'b0;
    result.status         = ST_OK;

    if (restart) begin
      if (phase != PH_IDLE) begin
        phase_next            = PH_IDLE;
        block_bytes_left_next = 5'd0;
        data_bytes_left_next  = 8'd0;
        crc_field_phase_next  = CF_DATA;
        running_crc_next      = 16'd0;
        crc_high_byte_next    = 8'd0;
        frame_error_next      = 1'b0;
        result.valid          = 1'b1;
        result.last           = 1'b1;
        result.status         = ST_ABORTED;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (rx_byte == SYNC_FIRST) begin
            phase_next = PH_SYNC2;
          end else begin
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = ST_BAD_SYNC;
          end
        end
        PH_SYNC2: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next = PH_LENGTH;
          end else begin
            phase_next    = PH_IDLE;
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = ST_BAD_SYNC;
          end
        end
        PH_LENGTH: begin
          if (rx_byte < FIRST_BLOCK_REST || rx_byte < limits.min_length ||
              rx_byte > limits.max_length) begin
            phase_next    = PH_IDLE;
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = ST_BAD_LENGTH;
          end else begin
            phase_next            = PH_FRAME;
            data_bytes_left_next  = rx_byte - FIRST_BLOCK_REST;
            block_bytes_left_next = FIRST_BLOCK_REST[4:0];
            crc_field_phase_next  = CF_DATA;
            running_crc_next      = crc_update(16'd0, rx_byte);
            frame_error_next      = 1'b0;
            result.valid          = 1'b1;
            result.data           = rx_byte;
          end
        end
        PH_FRAME: begin
          case (crc_field_phase)
            CF_DATA: begin
              running_crc_next      = crc_step;
              block_bytes_left_next = blk_dec;
              if (blk_dec == 5'd0) begin
                crc_field_phase_next = CF_HIGH;
              end
              if (!frame_error) begin
                result.valid = 1'b1;
                result.data  = rx_byte;
              end
            end
            CF_HIGH: begin
              crc_high_byte_next   = rx_byte;
              crc_field_phase_next = CF_LOW;
            end
            default: begin
              if (data_bytes_left == 8'd0) begin
                phase_next            = PH_IDLE;
                block_bytes_left_next = 5'd0;
                crc_field_phase_next  = CF_DATA;
                running_crc_next      = 16'd0;
                crc_high_byte_next    = 8'd0;
                frame_error_next      = 1'b0;
                result.valid          = 1'b1;
                result.last           = 1'b1;
                result.status         = (frame_error || crc_bad) ? ST_CRC_ERROR : ST_OK;
              end else begin
                frame_error_next      = frame_error || crc_bad;
                data_bytes_left_next  = data_bytes_left - {3'd0, next_size};
                block_bytes_left_next = next_size;
                running_crc_next      = 16'd0;
                crc_field_phase_next  = CF_DATA;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/wmfa_out_buf.sv
// Output register and skid stage; a full skid stage holds off input during a stall.
module wmfa_out_buf import wmfa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  result_t result,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  result_t main_item;
  result_t skid_item;
  logic    main_valid;
  logic    skid_valid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_item  = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= result.valid;
      end
    end else if (result.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_item <= skid_valid ? skid_item : result;
    end else if (result.valid && !skid_valid) begin
      skid_item <= result;
    end
  end

endmodule

>>> rtl/wmbus_format_a_deframer_core.sv
// Wireless M-Bus format A deframer with per-block CRC-16 check.
// Each result is combinational from its input beat and registered in the output buffer.
// Throughput: one input beat per cycle; a two-deep output buffer absorbs stalls until full.
// Reset: synchronous rst returns the parser to sync hunt, empties the output buffer and
// restores min_length to 9 and max_length to 200.
module wmbus_format_a_deframer_core import wmfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] restart
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,
  output logic [2:0]        m_tuser,   // [2:0] status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  limits_t limits;
  result_t result;
  result_t out_item;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  wmfa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  result_t parser_result;

  wmfa_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .restart (s_tuser),
    .limits  (limits),
    .result  (parser_result)
  );

  always_comb begin
    result       = parser_result;
    result.valid = parser_result.valid && accept;
  end

  wmfa_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = out_item.data;
  assign m_tlast = out_item.last;
  assign m_tuser = out_item.status;

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == 8'd0))
    else $error("Frame end beat carries a non-zero byte.");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK))
    else $error("Payload beat carries a non-ok status.");

  a_stall_shown: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("Input held off while no result is offered.");

endmodule

>>> tb/sv/wmbus_format_a_deframer_check.sv
// Checker for the format A deframer: predicts every output beat and compares it.
module wmbus_format_a_deframer_check import wmfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  input  logic              s_tuser,   // [0] restart
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,   // [7:0] out_byte
  input  logic              m_tlast,
  input  logic [2:0]        m_tuser,   // [2:0] status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } deframed_t;

  deframed_t   expected_q[$];
  logic [7:0]  lim_min;
  logic [7:0]  lim_max;
  phase_t      ph;
  logic [4:0]  blk_left;
  logic [7:0]  data_left;
  crc_field_t  cf;
  logic [15:0] crc;
  logic [7:0]  crc_hi;
  logic        frame_bad;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic report(input string what);
    errors++;
    $display("%0t deframer mismatch: %s", $time, what);
  endtask

  task automatic clear_frame();
    ph = PH_IDLE;
    blk_left = '0;
    data_left = '0;
    cf = CF_DATA;
    crc = '0;
    crc_hi = '0;
    frame_bad = 1'b0;
  endtask

  task automatic post(input logic [7:0] d, input logic l, input status_t s);
    deframed_t item;
    item.data = d;
    item.last = l;
    item.status = s;
    expected_q.push_back(item);
  endtask

  task automatic predict(input logic [7:0] b, input logic rs);
    logic [7:0] size;
    status_t    fin;
    if (rs) begin
      if (ph != PH_IDLE) begin
        clear_frame();
        post(8'h00, 1'b1, ST_ABORTED);
      end
    end else begin
      case (ph)
        PH_IDLE: begin
          if (b == SYNC_FIRST) ph = PH_SYNC2;
          else post(8'h00, 1'b1, ST_BAD_SYNC);
        end
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            ph = PH_LENGTH;
          end else begin
            clear_frame();
            post(8'h00, 1'b1, ST_BAD_SYNC);
          end
        end
        PH_LENGTH: begin
          if (b < FIRST_BLOCK_REST || b < lim_min || b > lim_max) begin
            clear_frame();
            post(8'h00, 1'b1, ST_BAD_LENGTH);
          end else begin
            ph = PH_FRAME;
            data_left = b - FIRST_BLOCK_REST;
            blk_left = FIRST_BLOCK_REST[4:0];
            cf = CF_DATA;
            crc = crc16_byte(16'h0000, b);
            frame_bad = 1'b0;
            post(b, 1'b0, ST_OK);
          end
        end
        default: begin
          case (cf)
            CF_DATA: begin
              crc = crc16_byte(crc, b);
              if (blk_left != 0) blk_left--;
              if (blk_left == 0) cf = CF_HIGH;
              if (!frame_bad) post(b, 1'b0, ST_OK);
            end
            CF_HIGH: begin
              crc_hi = b;
              cf = CF_LOW;
            end
            default: begin
              if ({crc_hi, b} != ~crc) frame_bad = 1'b1;
              if (data_left == 0) begin
                fin = frame_bad ? ST_CRC_ERROR : ST_OK;
                clear_frame();
                post(8'h00, 1'b1, fin);
              end else begin
                size = (data_left > FULL_BLOCK) ? FULL_BLOCK : data_left;
                data_left = data_left - size;
                blk_left = size[4:0];
                crc = '0;
                cf = CF_DATA;
              end
            end
          endcase
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    deframed_t want;
    if (rst) begin
      errors = 0;
      lim_min = MIN_LENGTH_RST;
      lim_max = MAX_LENGTH_RST;
      clear_frame();
      expected_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_MIN_LENGTH) lim_min = pwdata[7:0];
          else if (paddr == ADDR_MAX_LENGTH) lim_max = pwdata[7:0];
        end else if (paddr == ADDR_MIN_LENGTH && prdata[7:0] != lim_min) begin
          report($sformatf("min_length read %0d, expected %0d", prdata[7:0], lim_min));
        end else if (paddr == ADDR_MAX_LENGTH && prdata[7:0] != lim_max) begin
          report($sformatf("max_length read %0d, expected %0d", prdata[7:0], lim_max));
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected output beat data %02h last %0b status %0d",
                           m_tdata, m_tlast, m_tuser));
        end else begin
          want = expected_q.pop_front();
          if (m_tdata != want.data)
            report($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
          if (m_tlast != want.last)
            report($sformatf("frame_end %0b, expected %0b", m_tlast, want.last));
          if (m_tuser != want.status)
            report($sformatf("status %0d, expected %0d", m_tuser, want.status));
        end
      end
      if (s_tvalid && s_tready) predict(s_tdata, s_tuser);
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> tb/sv/wmbus_format_a_deframer_core_test.sv
// Stimulus and verdict for the format A deframer core.
module wmbus_format_a_deframer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wmfa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tlast;
  logic [2:0]        m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                outstanding;

  int         beats_sent = 0;
  int         burst_left = 0;
  int         hold_requests = 0;
  int         holds_done = 0;
  logic [7:0] cur_min = MIN_LENGTH_RST;
  logic [7:0] cur_max = MAX_LENGTH_RST;

  wmbus_format_a_deframer_core u_top (.*);
  wmbus_format_a_deframer_check u_check (.*);

  always #5 clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("wmbus_format_a_deframer_core_test: errors");
    $finish;
  end

  initial begin
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 100);
      end
      mode_left--;
      tick++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (tick % 3 != 0);
      endcase
    end
  end

  function automatic logic [15:0] frame_crc(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic rs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= rs;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    beats_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] a, input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= {24'h000000, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] mn, input logic [7:0] mx);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    settle();
    apb_access(1'b1, ADDR_MIN_LENGTH, mn);
    apb_access(1'b1, ADDR_MAX_LENGTH, mx);
    apb_access(1'b0, ADDR_MIN_LENGTH, 8'h00);
    apb_access(1'b0, ADDR_MAX_LENGTH, 8'h00);
    cur_min = mn;
    cur_max = mx;
  endtask

  // Builds a well-formed frame, optionally with one flipped bit or a restart part way in.
  task automatic send_frame(input logic [7:0] len, input bit corrupt, input bit abort);
    logic [7:0]  body[$];
    logic [15:0] c;
    logic [7:0]  r;
    int          left;
    int          size;
    int          dmg;
    int          cut;
    body.push_back(len);
    c = frame_crc(16'h0000, len);
    size = FIRST_BLOCK_REST;
    left = int'(len) - int'(FIRST_BLOCK_REST);
    while (1) begin
      repeat (size) begin
        r = 8'($urandom_range(0, 255));
        body.push_back(r);
        c = frame_crc(c, r);
      end
      body.push_back(~c[15:8]);
      body.push_back(~c[7:0]);
      if (left == 0) break;
      size = (left > FULL_BLOCK) ? FULL_BLOCK : left;
      left -= size;
      c = 16'h0000;
    end
    dmg = -1;
    cut = -1;
    if (corrupt) dmg = $urandom_range(0, body.size() - 1);
    if (abort) cut = $urandom_range(0, body.size() - 1);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(SYNC_SECOND, 1'b0);
    for (int i = 0; i < body.size(); i++) begin
      if (i == cut) begin
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        break;
      end
      r = body[i];
      if (i == dmg) r = r ^ (8'h01 << $urandom_range(0, 7));
      send_beat(r, 1'b0);
    end
  endtask

  task automatic random_traffic(input int target);
    int         kind;
    int         lo;
    int         hi;
    int         len;
    logic [7:0] r;
    while (beats_sent < target) begin
      lo = (cur_min < FIRST_BLOCK_REST) ? FIRST_BLOCK_REST : cur_min;
      hi = cur_max;
      kind = $urandom_range(0, 99);
      if (kind < 60 && lo <= hi) begin
        len = lo + $urandom_range(0, (hi - lo > 24) ? 24 : hi - lo);
        if ($urandom_range(0, 19) == 0) len = hi;
        send_frame(len[7:0], $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
      end else if (kind < 70) begin
        send_beat(SYNC_FIRST, 1'b0);
        send_beat(SYNC_SECOND, 1'b0);
        do r = 8'($urandom_range(0, 255));
        while (!(r < FIRST_BLOCK_REST || r < cur_min || r > cur_max));
        send_beat(r, 1'b0);
      end else if (kind < 80) begin
        send_beat(SYNC_FIRST, 1'b0);
        do r = 8'($urandom_range(0, 255)); while (r == SYNC_SECOND);
        send_beat(r, 1'b0);
      end else if (kind < 90) begin
        do r = 8'($urandom_range(0, 255)); while (r == SYNC_FIRST);
        send_beat(r, 1'b0);
      end else begin
        len = $urandom_range(0, 2);
        if (len > 0) send_beat(SYNC_FIRST, 1'b0);
        if (len > 1) send_beat(SYNC_SECOND, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    logic [7:0] mn;
    logic [7:0] mx;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(SYNC_SECOND, 1'b0);
    send_beat(8'h08, 1'b0);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(SYNC_SECOND, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(SYNC_FIRST, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_frame(8'd9, 1'b0, 1'b0);

    random_traffic(50);

    // The downstream side holds off while a long frame streams in, so the core backs up.
    set_limits(8'd255, 8'd255);
    hold_requests++;
    send_frame(8'd255, 1'b0, 1'b0);

    set_limits(8'd200, 8'd9);
    random_traffic(beats_sent + 10);

    set_limits(8'd9, 8'd9);
    random_traffic(beats_sent + 15);

    mn = 8'($urandom_range(9, 40));
    mx = 8'($urandom_range(mn, 64));
    set_limits(mn, mx);
    random_traffic(beats_sent + 20);

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("wmbus_format_a_deframer_core_test: clean");
    end else begin
      $display("wmbus_format_a_deframer_core_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wmfa_pkg.sv
rtl/wmfa_cfg_regs.sv
rtl/wmfa_parser.sv
rtl/wmfa_out_buf.sv
rtl/wmbus_format_a_deframer_core.sv
tb/sv/wmbus_format_a_deframer_check.sv
tb/sv/wmbus_format_a_deframer_core_test.sv
